// ===== hw/rtl/nfa_pkg.sv =====
// Shared types and constants for the NOR flash array model.
// Used by nfa_lane, nfa_merge, nor_flash_array_model and the testbench; no dependencies.

package nfa_pkg;

    // Array geometry
    localparam int LANES          = 8;
    localparam int LANE_BITS      = 3;
    localparam int ADDR_BITS      = 12;
    localparam int LEN_BITS       = 13;
    localparam int TOTAL_BYTES    = 4096;
    localparam int ROWS           = TOTAL_BYTES / LANES;
    localparam int ROW_BITS       = ADDR_BITS - LANE_BITS;
    localparam int ROW_CNT_BITS   = ROW_BITS + 1;
    localparam int SECTOR_BITS    = 8;
    localparam int MAX_READ_BYTES = 512;

    localparam logic [7:0] ERASED_RESET = 8'hFF;

    // Command codes
    localparam logic [2:0] OP_READ        = 3'd0;
    localparam logic [2:0] OP_PROGRAM     = 3'd1;
    localparam logic [2:0] OP_ERASE       = 3'd2;
    localparam logic [2:0] OP_BLANK_CHECK = 3'd3;
    localparam logic [2:0] OP_ERASE_ALL   = 3'd4;

    // Request on the input channel
    typedef struct packed {
        logic [2:0]           op;
        logic [ADDR_BITS-1:0] address;
        logic [LEN_BITS-1:0]  length;
        logic [63:0]          program_data;
    } in_item_t;

    // Result on the output channel
    typedef struct packed {
        logic        job_ok;
        logic [63:0] read_data;
        logic [3:0]  valid_bytes;
        logic        last;
    } out_item_t;

    // Per-lane command from the sequencer
    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic                wr_prog;   // write rdata & ref_byte instead of ref_byte
        logic [ROW_BITS-1:0] row;
        logic [7:0]          ref_byte;  // erased value, program byte or fill byte
    } lane_cmd_t;

    // Per-lane status back to the merge stage
    typedef struct packed {
        logic [7:0] data;
        logic       blank_bad;
        logic       prog_bad;
    } lane_stat_t;

    // Merged view of one row access
    typedef struct packed {
        logic [63:0] data;
        logic        blank_fail;
        logic        prog_fail;
    } merge_t;

endpackage

// ===== hw/rtl/nfa_lane.sv =====
// One byte lane of the flash array: a bank of ROWS bytes plus its checks.
// Depends on nfa_pkg.

module nfa_lane (
    input  logic               aclk,
    input  nfa_pkg::lane_cmd_t cmd,
    output nfa_pkg::lane_stat_t stat
);

    logic [7:0] mem [nfa_pkg::ROWS];
    logic [7:0] rdata_reg;
    logic [7:0] wr_data;

    // Program can only clear bits; erase writes the fill byte
    assign wr_data = cmd.wr_prog ? (rdata_reg & cmd.ref_byte) : cmd.ref_byte;

    // Bank: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.row] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[cmd.row];
        end
    end

    // Checks on the byte just read
    always_comb begin
        stat.data      = rdata_reg;
        stat.blank_bad = (rdata_reg != cmd.ref_byte);
        stat.prog_bad  = ((cmd.ref_byte & rdata_reg) != cmd.ref_byte);
    end

endmodule

// ===== hw/rtl/nfa_merge.sv =====
// Merge stage: rotates lane bytes into address order and ORs the lane checks.
// Depends on nfa_pkg.

module nfa_merge (
    input  nfa_pkg::lane_stat_t           stat [nfa_pkg::LANES],
    input  logic [nfa_pkg::LANE_BITS-1:0] start_lane,
    input  logic [nfa_pkg::LANES-1:0]     pos_mask,
    output nfa_pkg::merge_t               merged
);

    logic [nfa_pkg::LANE_BITS-1:0] bank;

    // Byte position i comes from bank (start_lane + i) mod LANES
    always_comb begin
        merged = '0;
        bank   = '0;
        for (int i = 0; i < nfa_pkg::LANES; i++) begin
            bank = start_lane + nfa_pkg::LANE_BITS'(i);
            if (pos_mask[i]) begin
                merged.data[i*8 +: 8] = stat[bank].data;
                merged.blank_fail     = merged.blank_fail | stat[bank].blank_bad;
                merged.prog_fail      = merged.prog_fail | stat[bank].prog_bad;
            end
        end
    end

endmodule

// ===== hw/rtl/nor_flash_array_model.sv =====
// NOR flash array model: 4096 bytes in eight byte banks of 512 rows, one command
// in flight at a time. After reset a clearing pass writes 0xFF to one row of all
// banks per cycle while s_ready stays low. Each request is accepted when idle.
// A read alternates issue and data states for each result of up to eight bytes;
// the data state posts it, waiting while the output stalls. A program reads,
// then checks and writes; an erase fills its rows, a blank check scans them and
// erase-all fills all rows, each then posting its result from the result state,
// as failed and zero-length commands do. Banks give one row access per cycle.
// Depends on nfa_pkg, nfa_lane and nfa_merge.

module nor_flash_array_model (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nfa_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output nfa_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ_ISSUE,
        S_READ_DATA,
        S_PROG_RD,
        S_PROG_CHECK,
        S_SCAN,
        S_SCAN_END,
        S_FILL,
        S_RESULT
    } state_t;

    state_t                               state_reg;
    logic [7:0]                           erased_value_reg;
    logic [nfa_pkg::LANE_BITS-1:0]        a0_reg;
    logic [nfa_pkg::ADDR_BITS-1:0]        base_reg;
    logic [nfa_pkg::LEN_BITS-1:0]         remain_reg;
    logic [63:0]                          prog_reg;
    logic [nfa_pkg::LANES-1:0]            mask_reg;
    logic [3:0]                           n_reg;
    logic                                 cmp_valid_reg;
    logic                                 fail_reg;
    logic                                 res_ok_reg;
    logic [nfa_pkg::ROW_BITS-1:0]         fill_row_reg;
    logic [nfa_pkg::ROW_CNT_BITS-1:0]     fill_left_reg;
    logic                                 m_valid_reg;
    nfa_pkg::out_item_t                   m_data_reg;

    logic                                 out_free;
    logic                                 post_result;
    logic [nfa_pkg::ADDR_BITS+1:0]        end_addr;
    logic                                 in_bounds;
    logic [3:0]                           issue_n;
    logic [nfa_pkg::LANES-1:0]            issue_mask;
    logic [nfa_pkg::LANE_BITS-1:0]        lane_idx [nfa_pkg::LANES];
    logic [nfa_pkg::ADDR_BITS-1:0]        lane_addr [nfa_pkg::LANES];
    nfa_pkg::lane_cmd_t                   lane_cmd [nfa_pkg::LANES];
    nfa_pkg::lane_stat_t                  lane_stat [nfa_pkg::LANES];
    nfa_pkg::merge_t                      merged;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // A result is loaded into the output register this cycle
    assign post_result = out_free && (state_reg == S_READ_DATA || state_reg == S_RESULT);

    // Range check without wrap
    assign end_addr  = (nfa_pkg::ADDR_BITS+2)'(s_data.address)
                     + (nfa_pkg::ADDR_BITS+2)'(s_data.length);
    assign in_bounds = (end_addr <= (nfa_pkg::ADDR_BITS+2)'(nfa_pkg::TOTAL_BYTES));

    // Bytes covered by the current row access
    assign issue_n = (remain_reg > nfa_pkg::LEN_BITS'(nfa_pkg::LANES))
                   ? 4'(nfa_pkg::LANES) : remain_reg[3:0];

    always_comb begin
        for (int i = 0; i < nfa_pkg::LANES; i++) begin
            issue_mask[i] = (4'(i) < issue_n);
        end
    end

    // Per-lane commands: lane l holds byte position (l - a0) of the chunk
    always_comb begin
        for (int l = 0; l < nfa_pkg::LANES; l++) begin
            lane_idx[l]  = nfa_pkg::LANE_BITS'(l) - a0_reg;
            lane_addr[l] = base_reg + nfa_pkg::ADDR_BITS'(lane_idx[l]);
            lane_cmd[l].rd_en    = 1'b0;
            lane_cmd[l].wr_en    = 1'b0;
            lane_cmd[l].wr_prog  = 1'b0;
            lane_cmd[l].row      = lane_addr[l][nfa_pkg::ADDR_BITS-1:nfa_pkg::LANE_BITS];
            lane_cmd[l].ref_byte = erased_value_reg;
            unique case (state_reg)
                S_CLEAR: begin
                    lane_cmd[l].wr_en    = 1'b1;
                    lane_cmd[l].row      = fill_row_reg;
                    lane_cmd[l].ref_byte = nfa_pkg::ERASED_RESET;
                end
                S_FILL: begin
                    lane_cmd[l].wr_en = 1'b1;
                    lane_cmd[l].row   = fill_row_reg;
                end
                S_READ_ISSUE, S_SCAN: begin
                    lane_cmd[l].rd_en = 1'b1;
                end
                S_PROG_RD: begin
                    lane_cmd[l].rd_en    = 1'b1;
                    lane_cmd[l].ref_byte = prog_reg[lane_idx[l]*8 +: 8];
                end
                S_PROG_CHECK: begin
                    lane_cmd[l].ref_byte = prog_reg[lane_idx[l]*8 +: 8];
                    lane_cmd[l].wr_prog  = 1'b1;
                    lane_cmd[l].wr_en    = mask_reg[lane_idx[l]] && !merged.prog_fail;
                end
                default: begin
                end
            endcase
        end
    end

    // Byte lanes
    for (genvar g = 0; g < nfa_pkg::LANES; g++) begin : g_lane
        nfa_lane u_lane (
            .aclk (aclk),
            .cmd  (lane_cmd[g]),
            .stat (lane_stat[g])
        );
    end

    nfa_merge u_merge (
        .stat       (lane_stat),
        .start_lane (a0_reg),
        .pos_mask   (mask_reg),
        .merged     (merged)
    );

    // Command sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            fill_row_reg     <= '0;
            fill_left_reg    <= nfa_pkg::ROW_CNT_BITS'(nfa_pkg::ROWS);
            m_valid_reg      <= 1'b0;
            erased_value_reg <= nfa_pkg::ERASED_RESET;
        end else begin
            if (cfg_wr_en) begin
                erased_value_reg <= cfg_wr_data;
            end
            // Output valid: set on a new result, cleared once taken
            if (post_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR, S_FILL: begin
                    fill_row_reg  <= fill_row_reg + 1'b1;
                    fill_left_reg <= fill_left_reg - 1'b1;
                    if (fill_left_reg == nfa_pkg::ROW_CNT_BITS'(1)) begin
                        state_reg <= (state_reg == S_CLEAR) ? S_IDLE : S_RESULT;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        a0_reg        <= s_data.address[nfa_pkg::LANE_BITS-1:0];
                        base_reg      <= s_data.address;
                        remain_reg    <= s_data.length;
                        prog_reg      <= s_data.program_data;
                        fail_reg      <= 1'b0;
                        cmp_valid_reg <= 1'b0;
                        res_ok_reg    <= 1'b0;
                        state_reg     <= S_RESULT;
                        unique case (s_data.op)
                            nfa_pkg::OP_READ: begin
                                if (in_bounds && s_data.length <=
                                    nfa_pkg::LEN_BITS'(nfa_pkg::MAX_READ_BYTES)) begin
                                    if (s_data.length == '0) begin
                                        res_ok_reg <= 1'b1;
                                    end else begin
                                        state_reg <= S_READ_ISSUE;
                                    end
                                end
                            end
                            nfa_pkg::OP_PROGRAM: begin
                                if (in_bounds && s_data.length <=
                                    nfa_pkg::LEN_BITS'(nfa_pkg::LANES)) begin
                                    if (s_data.length == '0) begin
                                        res_ok_reg <= 1'b1;
                                    end else begin
                                        state_reg <= S_PROG_RD;
                                    end
                                end
                            end
                            nfa_pkg::OP_ERASE: begin
                                if (in_bounds
                                    && s_data.address[nfa_pkg::SECTOR_BITS-1:0] == '0
                                    && s_data.length[nfa_pkg::SECTOR_BITS-1:0] == '0) begin
                                    res_ok_reg    <= 1'b1;
                                    fill_row_reg  <= s_data.address[nfa_pkg::ADDR_BITS-1:
                                                                    nfa_pkg::LANE_BITS];
                                    fill_left_reg <= s_data.length[nfa_pkg::LEN_BITS-1:
                                                                   nfa_pkg::LANE_BITS];
                                    if (s_data.length != '0) begin
                                        state_reg <= S_FILL;
                                    end
                                end
                            end
                            nfa_pkg::OP_BLANK_CHECK: begin
                                if (in_bounds) begin
                                    if (s_data.length == '0) begin
                                        res_ok_reg <= 1'b1;
                                    end else begin
                                        state_reg <= S_SCAN;
                                    end
                                end
                            end
                            nfa_pkg::OP_ERASE_ALL: begin
                                res_ok_reg    <= 1'b1;
                                fill_row_reg  <= '0;
                                fill_left_reg <= nfa_pkg::ROW_CNT_BITS'(nfa_pkg::ROWS);
                                state_reg     <= S_FILL;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ_ISSUE: begin
                    mask_reg   <= issue_mask;
                    n_reg      <= issue_n;
                    base_reg   <= base_reg + nfa_pkg::ADDR_BITS'(nfa_pkg::LANES);
                    remain_reg <= remain_reg - nfa_pkg::LEN_BITS'(issue_n);
                    state_reg  <= S_READ_DATA;
                end
                S_READ_DATA: begin
                    if (out_free) begin
                        m_data_reg.job_ok      <= 1'b1;
                        m_data_reg.read_data   <= merged.data;
                        m_data_reg.valid_bytes <= n_reg;
                        m_data_reg.last        <= (remain_reg == '0);
                        state_reg <= (remain_reg == '0) ? S_IDLE : S_READ_ISSUE;
                    end
                end
                S_PROG_RD: begin
                    mask_reg  <= issue_mask;
                    state_reg <= S_PROG_CHECK;
                end
                S_PROG_CHECK: begin
                    // lanes write this cycle when no byte would set a bit
                    res_ok_reg <= !merged.prog_fail;
                    state_reg  <= S_RESULT;
                end
                S_SCAN: begin
                    if (cmp_valid_reg && merged.blank_fail) begin
                        fail_reg <= 1'b1;
                    end
                    cmp_valid_reg <= 1'b1;
                    mask_reg      <= issue_mask;
                    base_reg      <= base_reg + nfa_pkg::ADDR_BITS'(nfa_pkg::LANES);
                    remain_reg    <= remain_reg - nfa_pkg::LEN_BITS'(issue_n);
                    if (remain_reg <= nfa_pkg::LEN_BITS'(nfa_pkg::LANES)) begin
                        state_reg <= S_SCAN_END;
                    end
                end
                S_SCAN_END: begin
                    res_ok_reg <= !(fail_reg || merged.blank_fail);
                    state_reg  <= S_RESULT;
                end
                S_RESULT: begin
                    if (out_free) begin
                        m_data_reg.job_ok      <= res_ok_reg;
                        m_data_reg.read_data   <= '0;
                        m_data_reg.valid_bytes <= '0;
                        m_data_reg.last        <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Testbench for nor_flash_array_model: directed and random flash commands, an
// array predictor kept in step with accepted requests, in-order result checks.
// Depends on nfa_pkg and the nor_flash_array_model RTL.

module testbench;
    import nfa_pkg::*;

    localparam int          SECTOR_BYTES    = 1 << SECTOR_BITS;
    localparam int          MAX_LENGTH      = (1 << LEN_BITS) - 1;
    localparam int          DRAIN_CYCLES    = 32;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          MAX_REPORTS     = 60;
    localparam logic [2:0]  OP_RESERVED_LO  = 3'd5;
    localparam logic [2:0]  OP_RESERVED_HI  = 3'd7;
    localparam logic [63:0] ALL_ONES        = '1;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    // Predicted array contents and erase byte
    logic [7:0] flash_image [TOTAL_BYTES];
    logic [7:0] erase_byte;
    out_item_t  pending_results[$];

    int         mismatch_count = 0;
    int         result_count = 0;
    int         gap_pct;
    int         stall_pct;
    logic       hold_off;

    nor_flash_array_model dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    // Receiver: random stalls, or a forced hold-off
    always @(posedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    function automatic void expect_result(logic ok, logic [63:0] data,
                                          logic [3:0] nbytes, logic fin);
        out_item_t r;
        r.job_ok      = ok;
        r.read_data   = data;
        r.valid_bytes = nbytes;
        r.last        = fin;
        pending_results.push_back(r);
    endfunction

    // Apply one accepted command to the array image and queue its results
    function automatic void predict_flash_command(in_item_t req);
        int unsigned base;
        int unsigned count;
        int unsigned chunk;
        int unsigned pos;
        int unsigned i;
        logic        fits;
        logic        clean;
        logic [63:0] word;
        logic [7:0]  b;
        base  = req.address;
        count = req.length;
        fits  = (base + count) <= TOTAL_BYTES;
        case (req.op)
            OP_READ: begin
                if (!fits || count > MAX_READ_BYTES) begin
                    expect_result(1'b0, '0, '0, 1'b1);
                end else if (count == 0) begin
                    expect_result(1'b1, '0, '0, 1'b1);
                end else begin
                    for (pos = 0; pos < count; pos += LANES) begin
                        chunk = (count - pos > LANES) ? LANES : count - pos;
                        word  = '0;
                        for (i = 0; i < chunk; i++) begin
                            word[8*i +: 8] = flash_image[base + pos + i];
                        end
                        expect_result(1'b1, word, 4'(chunk), (pos + chunk) >= count);
                    end
                end
            end
            OP_PROGRAM: begin
                if (!fits || count > LANES) begin
                    expect_result(1'b0, '0, '0, 1'b1);
                end else begin
                    // bits may only be cleared; any set bit rejects the whole request
                    clean = 1'b1;
                    for (i = 0; i < count; i++) begin
                        b = req.program_data[8*i +: 8];
                        if ((b & flash_image[base + i]) != b) clean = 1'b0;
                    end
                    if (clean) begin
                        for (i = 0; i < count; i++) begin
                            flash_image[base + i] &= req.program_data[8*i +: 8];
                        end
                    end
                    expect_result(clean, '0, '0, 1'b1);
                end
            end
            OP_ERASE: begin
                if ((base % SECTOR_BYTES) != 0 || (count % SECTOR_BYTES) != 0 || !fits) begin
                    expect_result(1'b0, '0, '0, 1'b1);
                end else begin
                    for (i = 0; i < count; i++) flash_image[base + i] = erase_byte;
                    expect_result(1'b1, '0, '0, 1'b1);
                end
            end
            OP_BLANK_CHECK: begin
                if (!fits) begin
                    expect_result(1'b0, '0, '0, 1'b1);
                end else begin
                    clean = 1'b1;
                    for (i = 0; i < count; i++) begin
                        if (flash_image[base + i] != erase_byte) clean = 1'b0;
                    end
                    expect_result(clean, '0, '0, 1'b1);
                end
            end
            OP_ERASE_ALL: begin
                for (i = 0; i < TOTAL_BYTES; i++) flash_image[i] = erase_byte;
                expect_result(1'b1, '0, '0, 1'b1);
            end
            default: begin
                expect_result(1'b0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d: none expected, got %h",
                                          result_count, m_data));
            end else begin
                want = pending_results.pop_front();
                if (m_data.job_ok !== want.job_ok)
                    report_mismatch($sformatf("result %0d: job_ok %b, expected %b",
                                              result_count, m_data.job_ok, want.job_ok));
                if (m_data.read_data !== want.read_data)
                    report_mismatch($sformatf("result %0d: read_data %h, expected %h",
                                              result_count, m_data.read_data,
                                              want.read_data));
                if (m_data.valid_bytes !== want.valid_bytes)
                    report_mismatch($sformatf("result %0d: valid_bytes %0d, expected %0d",
                                              result_count, m_data.valid_bytes,
                                              want.valid_bytes));
                if (m_data.last !== want.last)
                    report_mismatch($sformatf("result %0d: last %b, expected %b",
                                              result_count, m_data.last, want.last));
            end
        end
    end

    // Offer one request, holding it until accepted
    task automatic send_request(in_item_t req);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_flash_command(req);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write only with the block idle
    task automatic set_erased_value(logic [7:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        erase_byte  = value;
    endtask

    function automatic in_item_t make_request(logic [2:0] op, int unsigned addr,
                                              int unsigned len, logic [63:0] data = '0);
        in_item_t req;
        req.op           = op;
        req.address      = addr[ADDR_BITS-1:0];
        req.length       = len[LEN_BITS-1:0];
        req.program_data = data;
        return req;
    endfunction

    // Mostly the low kilobyte, so commands keep hitting the same bytes
    function automatic int unsigned near_address();
        return ($urandom_range(9) < 8) ? $urandom_range(1023) : $urandom_range(TOTAL_BYTES - 1);
    endfunction

    function automatic in_item_t random_request();
        in_item_t    req;
        int unsigned pick;
        int unsigned i;
        pick             = $urandom_range(99);
        req.program_data = {$urandom, $urandom};
        req.address      = ADDR_BITS'(near_address());
        if (pick < 5) begin
            // noise: any field value, reserved ops included
            req.op      = 3'($urandom_range(7));
            req.address = ADDR_BITS'($urandom_range(TOTAL_BYTES - 1));
            req.length  = LEN_BITS'($urandom_range(MAX_LENGTH));
        end else if (pick < 35) begin
            req.op     = OP_READ;
            req.length = LEN_BITS'(($urandom_range(9) == 0) ? $urandom_range(MAX_READ_BYTES + 8)
                                                            : $urandom_range(24));
        end else if (pick < 60) begin
            req.op     = OP_PROGRAM;
            req.length = LEN_BITS'(($urandom_range(9) == 0)
                                   ? $urandom_range(LANES + 1, 2 * LANES)
                                   : $urandom_range(LANES));
            // mostly data that only clears bits, so programs succeed
            if ($urandom_range(9) < 7) begin
                for (i = 0; i < LANES; i++) begin
                    if (req.address + i < TOTAL_BYTES)
                        req.program_data[8*i +: 8] = flash_image[req.address + i]
                                                     & 8'($urandom_range(255));
                end
            end
        end else if (pick < 72) begin
            req.op      = OP_ERASE;
            req.address = ADDR_BITS'($urandom_range(3) * SECTOR_BYTES);
            req.length  = LEN_BITS'($urandom_range(2) * SECTOR_BYTES);
            if ($urandom_range(7) == 0)
                req.address += ADDR_BITS'($urandom_range(1, SECTOR_BYTES - 1));
            if ($urandom_range(7) == 0)
                req.length  += LEN_BITS'($urandom_range(1, SECTOR_BYTES - 1));
        end else if (pick < 96) begin
            req.op = OP_BLANK_CHECK;
            if ($urandom_range(1) == 0) begin
                req.address = ADDR_BITS'($urandom_range(3) * SECTOR_BYTES);
                req.length  = LEN_BITS'(SECTOR_BYTES);
            end else begin
                req.length = LEN_BITS'($urandom_range(32));
            end
        end else begin
            req.op     = OP_ERASE_ALL;
            req.length = LEN_BITS'($urandom_range(MAX_LENGTH));
        end
        return req;
    endfunction

    // Field extremes, every op and each failure rule at the reset erase byte
    task automatic test_directed_commands();
        int unsigned k;
        gap_pct   = 0;
        stall_pct = 0;
        send_request(make_request(OP_READ, 0, 0));
        send_request(make_request(OP_READ, 0, LANES));
        send_request(make_request(OP_READ, TOTAL_BYTES - 1, 1));
        send_request(make_request(OP_READ, TOTAL_BYTES - MAX_READ_BYTES, MAX_READ_BYTES));
        send_request(make_request(OP_READ, 0, MAX_READ_BYTES + 1));
        send_request(make_request(OP_READ, TOTAL_BYTES - 1, 2));
        send_request(make_request(OP_READ, TOTAL_BYTES - 1, MAX_LENGTH));
        send_request(make_request(OP_PROGRAM, 16, LANES, 64'h0123_4567_89ab_cdef));
        send_request(make_request(OP_PROGRAM, 16, LANES, ALL_ONES));
        send_request(make_request(OP_PROGRAM, 16, 1, 64'h01));
        send_request(make_request(OP_PROGRAM, 24, LANES + 1, '0));
        send_request(make_request(OP_PROGRAM, 24, 0, '0));
        send_request(make_request(OP_PROGRAM, TOTAL_BYTES - 4, LANES, '0));
        send_request(make_request(OP_PROGRAM, TOTAL_BYTES - LANES, LANES, '0));
        send_request(make_request(OP_READ, 12, 16));
        send_request(make_request(OP_BLANK_CHECK, 0, 32));
        send_request(make_request(OP_BLANK_CHECK, SECTOR_BYTES, SECTOR_BYTES));
        send_request(make_request(OP_BLANK_CHECK, 0, 0));
        send_request(make_request(OP_BLANK_CHECK, 4000, 200));
        send_request(make_request(OP_ERASE, 0, SECTOR_BYTES));
        send_request(make_request(OP_ERASE, 8, SECTOR_BYTES));
        send_request(make_request(OP_ERASE, 0, 100));
        send_request(make_request(OP_ERASE, TOTAL_BYTES - SECTOR_BYTES, 2 * SECTOR_BYTES));
        send_request(make_request(OP_ERASE, 0, 0));
        for (k = OP_RESERVED_LO; k <= OP_RESERVED_HI; k++) begin
            send_request(make_request(3'(k), 0, LANES));
        end
        send_request(make_request(OP_ERASE_ALL, TOTAL_BYTES - 1, MAX_LENGTH, ALL_ONES));
        wait_for_results();
    endtask

    // Erase byte at both extremes and at 0xA5; stored bytes keep their old value
    task automatic test_erased_value();
        set_erased_value(8'h00);
        send_request(make_request(OP_ERASE, SECTOR_BYTES, SECTOR_BYTES));
        send_request(make_request(OP_BLANK_CHECK, SECTOR_BYTES, SECTOR_BYTES));
        send_request(make_request(OP_BLANK_CHECK, 2 * SECTOR_BYTES, LANES));
        send_request(make_request(OP_READ, SECTOR_BYTES, 16));
        send_request(make_request(OP_PROGRAM, SECTOR_BYTES, 4, '0));
        send_request(make_request(OP_PROGRAM, SECTOR_BYTES, 1, 64'h01));
        set_erased_value(8'hA5);
        send_request(make_request(OP_READ, SECTOR_BYTES, LANES));
        send_request(make_request(OP_BLANK_CHECK, SECTOR_BYTES, LANES));
        send_request(make_request(OP_ERASE_ALL, 0, 0));
        send_request(make_request(OP_BLANK_CHECK, 0, TOTAL_BYTES));
        send_request(make_request(OP_READ, TOTAL_BYTES - LANES, LANES));
        set_erased_value(8'hFF);
        send_request(make_request(OP_ERASE_ALL, 0, 0));
        wait_for_results();
    endtask

    task automatic test_random_commands(int sender_idle, int receiver_stall, int count);
        set_erased_value(8'($urandom_range(255)));
        gap_pct   = sender_idle;
        stall_pct = receiver_stall;
        repeat (count) send_request(random_request());
        wait_for_results();
    endtask

    // Long receiver hold-off while reads keep coming, so the input backs up
    task automatic test_output_backpressure();
        int unsigned n;
        gap_pct   = 0;
        stall_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off <= 1'b0;
            end
            begin
                for (n = 0; n < 12; n++) begin
                    send_request(make_request(OP_READ, $urandom_range(TOTAL_BYTES - 64),
                                              LANES * $urandom_range(1, 8)));
                end
            end
        join
        wait_for_results();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        hold_off       = 1'b0;
        gap_pct        = 0;
        stall_pct      = 0;
        erase_byte     = ERASED_RESET;
        foreach (flash_image[idx]) flash_image[idx] = ERASED_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_commands();
        test_erased_value();
        test_random_commands(0, 0, 20);
        test_random_commands(86, 0, 20);
        test_random_commands(0, 86, 20);
        test_random_commands(23, 23, 20);
        test_output_backpressure();
        wait_for_results();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/nfa_pkg.sv
hw/rtl/nfa_lane.sv
hw/rtl/nfa_merge.sv
hw/rtl/nor_flash_array_model.sv
verif/testbench.sv
